// ----- hw/rtl/kdef_pkg.sv -----
// Shared types, constants and helpers for the key debounce event FIFO.
// No dependencies; every other file of the block but kdef_ram imports this package.
package kdef_pkg;

    localparam int NUM_KEYS         = 6;
    localparam int KEY_IDX_W        = 3;
    localparam int CODE_W           = 5;
    localparam int FUNC_W           = 2;
    localparam int RAW_W            = 3;
    localparam int LONG_W           = 16;
    localparam int REP_W            = 8;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 16;
    localparam int FILTER_TICKS_DEF = 5;
    localparam int RING_DEPTH_DEF   = 16;

    localparam logic [LONG_W-1:0] LONG_TIME_RST    = LONG_W'(100);
    localparam logic [REP_W-1:0]  REPEAT_SPEED_RST = '0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_SPEED = 2'd1;

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_SCAN  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ2 = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

    // Event kinds, added to 3*key
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;
    localparam logic [1:0] EV_LONG    = 2'd3;

    localparam logic [KEY_IDX_W-1:0] LAST_KEY = KEY_IDX_W'(NUM_KEYS - 1);

    typedef struct packed {
        logic                 load_in;
        logic                 key_step;
        logic                 key_wr2;
        logic                 rd_issue;
        logic                 rd_latch;
        logic                 clr_rd;
        logic                 out_load;
        logic [KEY_IDX_W-1:0] key_idx;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              rd_empty;
        logic              two_codes;
    } t_sts;

    function automatic logic [CODE_W-1:0] key_code_of(input logic [KEY_IDX_W-1:0] idx,
                                                      input logic [1:0] kind);
        return CODE_W'({idx, 1'b0}) + CODE_W'(idx) + CODE_W'(kind);
    endfunction

endpackage

// ----- hw/rtl/kdef_req_if.sv -----
// Request channel of the key debounce event FIFO: valid/ready plus func and raw keys.
// Depends on kdef_pkg.
interface kdef_req_if;
    import kdef_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [RAW_W-1:0]  raw_keys;

    modport source(output valid, output func, output raw_keys, input ready);
    modport sink(input valid, input func, input raw_keys, output ready);
endinterface

// ----- hw/rtl/kdef_rsp_if.sv -----
// Response channel of the key debounce event FIFO: valid/ready plus code and key states.
// Depends on kdef_pkg.
interface kdef_rsp_if;
    import kdef_pkg::*;

    logic                valid;
    logic                ready;
    logic [CODE_W-1:0]   key_code;
    logic [NUM_KEYS-1:0] key_states;

    modport source(output valid, output key_code, output key_states, input ready);
    modport sink(input valid, input key_code, input key_states, output ready);
endinterface

// ----- hw/rtl/kdef_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kdef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/kdef_ctrl.sv -----
// Sequencer of the key debounce event FIFO: handshakes, key walk and ring access steps.
// Depends on kdef_pkg; drives kdef_datapath through t_cmd and watches t_sts.
module kdef_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  kdef_pkg::t_sts  i_sts,
    output kdef_pkg::t_cmd  o_cmd
);
    import kdef_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DISP  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_SCAN2 = 3'd3;
    localparam logic [2:0] ST_RDREQ = 3'd4;
    localparam logic [2:0] ST_RDLAT = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [KEY_IDX_W-1:0] r_idx, n_idx;
    logic                 r_ovalid, n_ovalid;
    t_cmd                 cmd;

    always_comb begin
        cmd         = '0;
        cmd.key_idx = r_idx;
        n_state     = r_state;
        n_idx       = r_idx;
        cmd.load_in = (r_state == ST_IDLE) && i_in_valid;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                n_idx = '0;
                case (i_sts.func)
                    FUNC_SCAN:  n_state = ST_SCAN;
                    FUNC_READ:  n_state = ST_RDREQ;
                    FUNC_READ2: n_state = ST_RDREQ;
                    FUNC_CLEAR: begin
                        cmd.clr_rd = 1'b1;
                        n_state    = ST_FIN;
                    end
                    default:    n_state = ST_FIN;
                endcase
            end
            ST_SCAN: begin
                cmd.key_step = 1'b1;
                if (i_sts.two_codes) begin
                    n_state = ST_SCAN2;
                end else if (r_idx == LAST_KEY) begin
                    n_state = ST_FIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_SCAN2: begin
                // flush the second code of this key before moving on
                cmd.key_wr2 = 1'b1;
                if (r_idx == LAST_KEY) begin
                    n_state = ST_FIN;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_RDREQ: begin
                if (i_sts.rd_empty) begin
                    n_state = ST_FIN;
                end else begin
                    cmd.rd_issue = 1'b1;
                    n_state      = ST_RDLAT;
                end
            end
            ST_RDLAT: begin
                cmd.rd_latch = 1'b1;
                n_state      = ST_FIN;
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!r_ovalid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_cmd       = cmd;
endmodule

// ----- hw/rtl/kdef_datapath.sv -----
// Datapath of the key debounce event FIFO: per-key debounce state, config registers,
// ring pointers and output register. Depends on kdef_pkg and kdef_ram.
module kdef_datapath #(
    parameter int FILTER_TICKS = kdef_pkg::FILTER_TICKS_DEF,
    parameter int RING_DEPTH   = kdef_pkg::RING_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kdef_pkg::t_cmd                i_cmd,
    output kdef_pkg::t_sts                o_sts,
    input  logic [kdef_pkg::FUNC_W-1:0]   i_func,
    input  logic [kdef_pkg::RAW_W-1:0]    i_raw_keys,
    input  logic                          i_cfg_we,
    input  logic [kdef_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kdef_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic [kdef_pkg::CODE_W-1:0]   o_key_code,
    output logic [kdef_pkg::NUM_KEYS-1:0] o_key_states
);
    import kdef_pkg::*;

    localparam int CW = $clog2(2 * FILTER_TICKS + 1);
    localparam int PW = $clog2(RING_DEPTH);
    localparam logic [CW-1:0] CNT_F   = CW'(FILTER_TICKS);
    localparam logic [CW-1:0] CNT_2F  = CW'(2 * FILTER_TICKS);
    localparam logic [CW-1:0] CNT_RST = CW'(FILTER_TICKS / 2);
    localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);

    logic [FUNC_W-1:0]   r_func;
    logic [RAW_W-1:0]    r_raw;
    logic [LONG_W-1:0]   r_long;
    logic [REP_W-1:0]    r_rspd;
    logic [NUM_KEYS-1:0] r_press;
    logic [CW-1:0]       r_deb  [NUM_KEYS];
    logic [LONG_W-1:0]   r_held [NUM_KEYS];
    logic [REP_W-1:0]    r_rep  [NUM_KEYS];
    logic [PW-1:0]       r_wptr, r_rptr, r_rptr2;
    logic [CODE_W-1:0]   r_pend;
    logic [CODE_W-1:0]   r_code;
    logic [CODE_W-1:0]   r_ocode;
    logic [NUM_KEYS-1:0] r_ostates;

    logic [NUM_KEYS-1:0] down;
    logic [CW-1:0]       cnt, n_cnt;
    logic                st, n_st;
    logic [LONG_W-1:0]   held, n_held;
    logic [REP_W-1:0]    rep, n_rep;
    logic [REP_W:0]      rep_inc;
    logic                a_vld, b_vld;
    logic [CODE_W-1:0]   code_a, code_b;
    logic                ram_we;
    logic [CODE_W-1:0]   ram_wdata;
    logic [CODE_W-1:0]   ram_rdata;
    logic [PW-1:0]       rd_ptr;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign down[0] = r_raw[0];
    assign down[1] = r_raw[1];
    assign down[2] = r_raw[2];
    assign down[3] = r_raw[0] & r_raw[1];
    assign down[4] = r_raw[0] & r_raw[2];
    assign down[5] = r_raw[1] & r_raw[2];

    // One key update per step for the key the sequencer points at
    always_comb begin
        cnt     = r_deb[i_cmd.key_idx];
        st      = r_press[i_cmd.key_idx];
        held    = r_held[i_cmd.key_idx];
        rep     = r_rep[i_cmd.key_idx];
        rep_inc = {1'b0, rep} + 1'b1;
        n_cnt   = cnt;
        n_st    = st;
        n_held  = held;
        n_rep   = rep;
        a_vld   = 1'b0;
        b_vld   = 1'b0;
        code_a  = key_code_of(i_cmd.key_idx, EV_PRESS);
        code_b  = key_code_of(i_cmd.key_idx, EV_LONG);
        if (down[i_cmd.key_idx]) begin
            if (cnt < CNT_F) begin
                n_cnt = CNT_F;
            end else if (cnt < CNT_2F) begin
                n_cnt = cnt + 1'b1;
            end else begin
                if (!st) begin
                    n_st  = 1'b1;
                    a_vld = 1'b1;
                end
                if (r_long != '0) begin
                    if (held < r_long) begin
                        n_held = held + 1'b1;
                        if (n_held == r_long) begin
                            // long code follows a press code in the same tick
                            if (a_vld) begin
                                b_vld = 1'b1;
                            end else begin
                                a_vld  = 1'b1;
                                code_a = key_code_of(i_cmd.key_idx, EV_LONG);
                            end
                        end
                    end else if (r_rspd != '0) begin
                        if (rep_inc >= {1'b0, r_rspd}) begin
                            n_rep = '0;
                            a_vld = 1'b1;
                        end else begin
                            n_rep = rep_inc[REP_W-1:0];
                        end
                    end
                end
            end
        end else begin
            if (cnt > CNT_F) begin
                n_cnt = CNT_F;
            end else if (cnt != '0) begin
                n_cnt = cnt - 1'b1;
            end else if (st) begin
                n_st   = 1'b0;
                a_vld  = 1'b1;
                code_a = key_code_of(i_cmd.key_idx, EV_RELEASE);
            end
            n_held = '0;
            n_rep  = '0;
        end
    end

    assign ram_we    = (i_cmd.key_step & a_vld) | i_cmd.key_wr2;
    assign ram_wdata = i_cmd.key_wr2 ? r_pend : code_a;
    assign rd_ptr    = (r_func == FUNC_READ2) ? r_rptr2 : r_rptr;

    kdef_ram #(
        .WIDTH(CODE_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_wptr),
        .i_wdata(ram_wdata),
        .i_raddr(rd_ptr),
        .o_rdata(ram_rdata)
    );

    // Control state: key state, pointers, config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long  <= LONG_TIME_RST;
            r_rspd  <= REPEAT_SPEED_RST;
            r_press <= '0;
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_rptr2 <= '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_deb[k]  <= CNT_RST;
                r_held[k] <= '0;
                r_rep[k]  <= '0;
            end
        end else begin
            if (i_cmd.key_step) begin
                r_deb[i_cmd.key_idx]   <= n_cnt;
                r_press[i_cmd.key_idx] <= n_st;
                r_held[i_cmd.key_idx]  <= n_held;
                r_rep[i_cmd.key_idx]   <= n_rep;
            end
            if (ram_we) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_cmd.clr_rd) begin
                r_rptr <= r_wptr;
            end
            if (i_cmd.rd_issue) begin
                if (r_func == FUNC_READ2) begin
                    r_rptr2 <= ptr_inc(r_rptr2);
                end else begin
                    r_rptr <= ptr_inc(r_rptr);
                end
            end
            if (i_cfg_we && (i_cfg_idx == CFG_LONG_TIME || i_cfg_idx == CFG_REPEAT_SPEED)) begin
                if (i_cfg_idx == CFG_LONG_TIME) begin
                    r_long <= i_cfg_wdata[LONG_W-1:0];
                end else begin
                    r_rspd <= i_cfg_wdata[REP_W-1:0];
                end
                for (int k = 0; k < NUM_KEYS; k++) begin
                    r_rep[k] <= '0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func <= i_func;
            r_raw  <= i_raw_keys;
            r_code <= '0;
        end
        if (i_cmd.key_step) begin
            r_pend <= code_b;
        end
        if (i_cmd.rd_latch) begin
            r_code <= ram_rdata;
        end
        if (i_cmd.out_load) begin
            r_ocode   <= r_code;
            r_ostates <= r_press;
        end
    end

    assign o_sts.func      = r_func;
    assign o_sts.rd_empty  = (rd_ptr == r_wptr);
    assign o_sts.two_codes = b_vld;
    assign o_key_code      = r_ocode;
    assign o_key_states    = r_ostates;
endmodule

// ----- hw/rtl/key_debounce_event_fifo.sv -----
// Top level of the key debounce event FIFO: sequencer, datapath and channel interfaces.
// Depends on kdef_pkg, kdef_req_if, kdef_rsp_if, kdef_ctrl and kdef_datapath.
//
// Six keys (three pins and the pairs 0+1, 0+2, 1+2) are debounced one per cycle on each
// scan request, with an extra step whenever a key writes a second code; press, release,
// long-press and repeat codes (3*key+1/+2/+3) go into a ring of RING_DEPTH entries that
// overwrites on wrap and has two independent readers. Every request gives one response
// with the read code (0 when empty or not a read) and the debounced key states. One
// request is in work at a time: a scan steps through the keys plus one write step per
// second code of a key, since the ring has a single write port, and a read waits for
// the registered ring read unless its reader is empty. A finished response waits in the
// output register while the next request is taken. Configuration writes take effect at once.
module key_debounce_event_fifo #(
    parameter int FILTER_TICKS = kdef_pkg::FILTER_TICKS_DEF,
    parameter int RING_DEPTH   = kdef_pkg::RING_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    kdef_req_if.sink                        i_req,
    kdef_rsp_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [kdef_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kdef_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import kdef_pkg::*;

    t_cmd cmd;
    t_sts sts;

    kdef_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .o_out_valid(o_rsp.valid),
        .i_out_ready(o_rsp.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    kdef_datapath #(
        .FILTER_TICKS(FILTER_TICKS),
        .RING_DEPTH  (RING_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_func      (i_req.func),
        .i_raw_keys  (i_req.raw_keys),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_key_code  (o_rsp.key_code),
        .o_key_states(o_rsp.key_states)
    );
endmodule

// ----- hw/rtl/kdef_checker.sv -----
// Port-level checks for the key debounce event FIFO, bound to the top level.
// Depends on kdef_pkg and key_debounce_event_fifo.
module kdef_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [kdef_pkg::CODE_W-1:0]   i_key_code,
    input logic [kdef_pkg::NUM_KEYS-1:0] i_key_states
);
    import kdef_pkg::*;

    localparam logic [CODE_W-1:0] CODE_MAX = key_code_of(LAST_KEY, EV_LONG);

    // no response right after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    // one request in work: no new request taken the cycle after acceptance
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while busy");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_key_code <= CODE_MAX)
        else $error("key code out of range");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_key_code) && $stable(i_key_states))
        else $error("stalled response changed");
endmodule

bind key_debounce_event_fifo kdef_checker u_kdef_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_key_code  (o_rsp.key_code),
    .i_key_states(o_rsp.key_states)
);

// ----- tb/sv/key_debounce_event_fifo_tb.sv -----
// Self-checking testbench for key_debounce_event_fifo: scan, read and reader-clear requests
// checked against an in-bench model of the debouncer and the two-reader event ring.
// Depends on kdef_pkg, kdef_req_if, kdef_rsp_if and the key_debounce_event_fifo RTL.
module key_debounce_event_fifo_tb;
    import kdef_pkg::*;

    localparam int KEYS  = NUM_KEYS;
    localparam int FILT  = FILTER_TICKS_DEF;
    localparam int DEPTH = RING_DEPTH_DEF;

    // Indexes past the last register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic [1:0] {ACT_REQ, ACT_CFG, ACT_DRAIN} t_act_kind;

    typedef struct {
        t_act_kind             kind;
        logic [FUNC_W-1:0]     func;
        logic [RAW_W-1:0]      raw;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_data;
    } t_action;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [NUM_KEYS-1:0] states;
    } t_key_rsp;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    kdef_req_if req_if ();
    kdef_rsp_if rsp_if ();

    key_debounce_event_fifo u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // Key and ring model
    logic [LONG_W-1:0] long_cfg;
    logic [REP_W-1:0]  repeat_cfg;
    logic              key_down   [KEYS];
    logic [3:0]        bounce_cnt [KEYS];
    logic [LONG_W-1:0] hold_ticks [KEYS];
    logic [REP_W-1:0]  rep_ticks  [KEYS];
    logic [CODE_W-1:0] code_ring  [DEPTH];
    int                ring_wr;
    int                ring_rd_a;
    int                ring_rd_b;

    t_action  action_q[$];
    t_key_rsp rsp_backlog[$];

    int   req_total;
    int   gap_left;
    int   stall_left;
    logic calm;
    logic req_taken;

    int fail_cnt;
    int rsp_seen;
    int scan_cnt;
    int code_hits;
    int cfg_writes;

    function automatic void reset_key_model();
        int k;
        long_cfg   = LONG_TIME_RST;
        repeat_cfg = REPEAT_SPEED_RST;
        for (k = 0; k < KEYS; k++) begin
            key_down[k]   = 1'b0;
            bounce_cnt[k] = 4'(FILT / 2);
            hold_ticks[k] = '0;
            rep_ticks[k]  = '0;
        end
        for (k = 0; k < DEPTH; k++) begin
            code_ring[k] = '0;
        end
        ring_wr   = 0;
        ring_rd_a = 0;
        ring_rd_b = 0;
    endfunction

    function automatic void push_code(input int k, input logic [1:0] kind);
        code_ring[ring_wr] = CODE_W'(3 * k + int'(kind));
        ring_wr = (ring_wr + 1) % DEPTH;
    endfunction

    function automatic logic [CODE_W-1:0] take_code(input logic second);
        int                ptr;
        logic [CODE_W-1:0] c;
        ptr = second ? ring_rd_b : ring_rd_a;
        if (ptr == ring_wr) return '0;
        c   = code_ring[ptr];
        ptr = (ptr + 1) % DEPTH;
        if (second) ring_rd_b = ptr;
        else ring_rd_a = ptr;
        return c;
    endfunction

    function automatic void scan_key(input int k, input logic down);
        if (down) begin
            if (bounce_cnt[k] < FILT) begin
                bounce_cnt[k] = 4'(FILT);
            end else if (bounce_cnt[k] < 2 * FILT) begin
                bounce_cnt[k]++;
            end else begin
                if (!key_down[k]) begin
                    key_down[k] = 1'b1;
                    push_code(k, EV_PRESS);
                end
                if (long_cfg != 0) begin
                    if (hold_ticks[k] < long_cfg) begin
                        hold_ticks[k]++;
                        if (hold_ticks[k] == long_cfg) push_code(k, EV_LONG);
                    end else if (repeat_cfg != 0) begin
                        rep_ticks[k]++;
                        if (rep_ticks[k] >= repeat_cfg) begin
                            rep_ticks[k] = '0;
                            push_code(k, EV_PRESS);
                        end
                    end
                end
            end
        end else begin
            if (bounce_cnt[k] > FILT) begin
                bounce_cnt[k] = 4'(FILT);
            end else if (bounce_cnt[k] != 0) begin
                bounce_cnt[k]--;
            end else if (key_down[k]) begin
                key_down[k] = 1'b0;
                push_code(k, EV_RELEASE);
            end
            hold_ticks[k] = '0;
            rep_ticks[k]  = '0;
        end
    endfunction

    function automatic t_key_rsp compute_key_response(input logic [FUNC_W-1:0] func,
                                                      input logic [RAW_W-1:0]  raw);
        t_key_rsp        r;
        logic [KEYS-1:0] down;
        int              k;
        r.code = '0;
        case (func)
            FUNC_SCAN: begin
                // combination keys follow the three pins
                down = {raw[1] & raw[2], raw[0] & raw[2], raw[0] & raw[1], raw};
                for (k = 0; k < KEYS; k++) scan_key(k, down[k]);
            end
            FUNC_READ:  r.code = take_code(1'b0);
            FUNC_READ2: r.code = take_code(1'b1);
            default:    ring_rd_a = ring_wr;
        endcase
        for (k = 0; k < KEYS; k++) r.states[k] = key_down[k];
        return r;
    endfunction

    function automatic void write_config(input logic [CFG_IDX_W-1:0]  idx,
                                         input logic [CFG_DATA_W-1:0] data);
        int k;
        case (idx)
            CFG_LONG_TIME:    long_cfg = data[LONG_W-1:0];
            CFG_REPEAT_SPEED: repeat_cfg = data[REP_W-1:0];
            default:          return;
        endcase
        for (k = 0; k < KEYS; k++) rep_ticks[k] = '0;
    endfunction

    // Stimulus builders
    function automatic void add_req(input logic [FUNC_W-1:0] f, input logic [RAW_W-1:0] r);
        t_action a;
        a.kind     = ACT_REQ;
        a.func     = f;
        a.raw      = r;
        a.cfg_idx  = '0;
        a.cfg_data = '0;
        action_q.push_back(a);
        req_total++;
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0]  idx,
                                    input logic [CFG_DATA_W-1:0] data);
        t_action a;
        a.kind     = ACT_CFG;
        a.func     = FUNC_SCAN;
        a.raw      = '0;
        a.cfg_idx  = idx;
        a.cfg_data = data;
        action_q.push_back(a);
    endfunction

    function automatic void add_drain();
        t_action a;
        a.kind     = ACT_DRAIN;
        a.func     = FUNC_SCAN;
        a.raw      = '0;
        a.cfg_idx  = '0;
        a.cfg_data = '0;
        action_q.push_back(a);
    endfunction

    function automatic void add_reads(input int n);
        int i;
        int pick;
        for (i = 0; i < n; i++) begin
            pick = $urandom_range(19);
            if (pick == 0) add_req(FUNC_CLEAR, RAW_W'($urandom));
            else if (pick < 10) add_req(FUNC_READ, RAW_W'($urandom));
            else add_req(FUNC_READ2, RAW_W'($urandom));
        end
    endfunction

    // Hold one pin pattern for n ticks, or bounce at random, with reads mixed in
    function automatic void add_hold(input logic [RAW_W-1:0] raw, input int n,
                                     input int read_pct, input logic bounce);
        int t;
        for (t = 0; t < n; t++) begin
            add_req(FUNC_SCAN, bounce ? RAW_W'($urandom) : raw);
            if ($urandom_range(99) < read_pct) add_reads($urandom_range(1, 3));
        end
    endfunction

    task automatic play_phase(input logic [LONG_W-1:0] lt, input logic [REP_W-1:0] rs,
                              input int budget, inout logic [RAW_W-1:0] carry);
        int start;
        int pick;
        start = req_total;
        add_cfg(CFG_LONG_TIME, lt);
        add_cfg(CFG_REPEAT_SPEED, {8'($urandom), rs});
        // keep holding what the last phase left pressed
        add_hold(carry, $urandom_range(4, 12), 30, 1'b0);
        while (req_total - start < budget) begin
            pick = $urandom_range(99);
            if (pick < 60) add_hold(RAW_W'($urandom), $urandom_range(1, 20), 35, 1'b0);
            else if (pick < 78) add_hold('0, $urandom_range(1, 10), 35, 1'b1);
            else if (pick < 95) add_reads($urandom_range(1, 20));
            else add_drain();
        end
        carry = RAW_W'($urandom_range(1, 7));
        add_hold(carry, $urandom_range(8, 16), 20, 1'b0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Drive both channels and the register port on the falling edge
    always @(negedge i_clk) begin
        t_action a;
        logic    nv;
        logic    nwe;
        logic    nrdy;
        logic    idle_ok;
        nwe  = 1'b0;
        nrdy = 1'b0;
        nv   = 1'b0;
        if (i_rst_n === 1'b1) begin
            nv      = req_if.valid && !req_taken;
            idle_ok = !calm && action_q.size() > 60;
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (action_q.size() > 0) begin
                    a = action_q[0];
                    if (a.kind == ACT_REQ) begin
                        nv = 1'b1;
                        req_if.func     <= a.func;
                        req_if.raw_keys <= a.raw;
                        void'(action_q.pop_front());
                        if ($urandom_range(99) < 3) calm = !calm;
                        if (idle_ok && $urandom_range(99) < 25) gap_left = $urandom_range(1, 17);
                    end else if (rsp_backlog.size() == 0) begin
                        // block is idle: registers may change now
                        if (a.kind == ACT_CFG) begin
                            nwe = 1'b1;
                            i_cfg_idx   <= a.cfg_idx;
                            i_cfg_wdata <= a.cfg_data;
                        end
                        void'(action_q.pop_front());
                    end
                end
            end
            nrdy = 1'b1;
            if (stall_left > 0) begin
                stall_left--;
                nrdy = 1'b0;
            end else if (idle_ok && $urandom_range(99) < 12) begin
                stall_left = $urandom_range(0, 16);
                nrdy = 1'b0;
            end
        end
        req_if.valid <= nv;
        i_cfg_we     <= nwe;
        rsp_if.ready <= nrdy;
    end

    // Sample handshakes on the rising edge, predict and check
    always @(posedge i_clk) begin
        t_key_rsp got;
        t_key_rsp want;
        req_taken <= (i_rst_n === 1'b1) && req_if.valid && req_if.ready;
        if (i_rst_n === 1'b1) begin
            if (i_cfg_we) begin
                write_config(i_cfg_idx, i_cfg_wdata);
                cfg_writes++;
            end
            // check before predicting: a response never belongs to a same-edge request
            if (rsp_if.valid && rsp_if.ready) begin
                got.code   = rsp_if.key_code;
                got.states = rsp_if.key_states;
                rsp_seen++;
                if (rsp_backlog.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected response: code %0d states %b",
                                 got.code, got.states);
                end else begin
                    want = rsp_backlog.pop_front();
                    if (want.code != 0) code_hits++;
                    if (got.code !== want.code || got.states !== want.states) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("mismatch at response %0d: code exp %0d got %0d, states exp %b got %b",
                                     rsp_seen, want.code, got.code, want.states, got.states);
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                if (req_if.func == FUNC_SCAN) scan_cnt++;
                rsp_backlog.push_back(compute_key_response(req_if.func, req_if.raw_keys));
            end
        end
    end

    initial begin
        logic [RAW_W-1:0] carry;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_wdata     = '0;
        req_if.valid    = 1'b0;
        req_if.func     = FUNC_SCAN;
        req_if.raw_keys = '0;
        rsp_if.ready    = 1'b0;
        req_taken       = 1'b0;
        calm            = 1'b0;
        gap_left        = 0;
        stall_left      = 0;
        req_total       = 0;
        fail_cnt        = 0;
        rsp_seen        = 0;
        scan_cnt        = 0;
        code_hits       = 0;
        cfg_writes      = 0;
        reset_key_model();

        // Directed: empty reads and clear from reset
        add_req(FUNC_READ, 3'b000);
        add_req(FUNC_READ2, 3'b111);
        add_req(FUNC_CLEAR, 3'b000);
        // Shortest long press and repeat; all six keys settle and the ring wraps
        add_cfg(CFG_LONG_TIME, 16'd1);
        add_cfg(CFG_REPEAT_SPEED, 16'd1);
        repeat (9) add_req(FUNC_SCAN, 3'b111);
        add_req(FUNC_READ, 3'b000);
        add_req(FUNC_READ, 3'b101);
        add_req(FUNC_READ2, 3'b010);
        add_req(FUNC_READ2, 3'b000);
        add_req(FUNC_CLEAR, 3'b111);
        add_req(FUNC_READ, 3'b000);
        // Release everything
        repeat (7) add_req(FUNC_SCAN, 3'b000);

        // Random phases across register settings
        carry = 3'b011;
        play_phase(16'hFFFF, 8'd3, 35, carry);
        add_drain();
        // held count is already past the new long time
        play_phase(16'd2, 8'd1, 35, carry);
        add_cfg(CFG_SPARE_A, 16'($urandom));
        add_cfg(CFG_SPARE_B, 16'($urandom));
        play_phase(16'd0, 8'd5, 35, carry);
        // slowest repeat: one hold long enough for a repeated press
        add_cfg(CFG_LONG_TIME, 16'd3);
        add_cfg(CFG_REPEAT_SPEED, 16'h00FF);
        add_hold(3'b101, 270, 8, 1'b0);
        add_hold(3'b000, 10, 50, 1'b0);
        add_reads(20);
        play_phase(LONG_W'($urandom_range(1, 12)), REP_W'($urandom_range(1, 4)), 35, carry);
        add_drain();
        play_phase(LONG_W'($urandom_range(0, 30)), REP_W'($urandom_range(0, 3)), 35, carry);
        add_hold(3'b000, 12, 0, 1'b0);
        add_reads(20);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (action_q.size() != 0 || req_if.valid || rsp_backlog.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Ran %0d requests: %0d scan ticks, %0d reads returned a key code, %0d register writes",
                 rsp_seen, scan_cnt, code_hits, cfg_writes);
        $display("Compared %0d responses with %0d failures", rsp_seen, fail_cnt);
        if (fail_cnt == 0 && rsp_backlog.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/kdef_pkg.sv
hw/rtl/kdef_req_if.sv
hw/rtl/kdef_rsp_if.sv
hw/rtl/kdef_ram.sv
hw/rtl/kdef_ctrl.sv
hw/rtl/kdef_datapath.sv
hw/rtl/key_debounce_event_fifo.sv
hw/rtl/kdef_checker.sv
tb/sv/key_debounce_event_fifo_tb.sv
